// ===== rtl/bba_pkg.sv =====
// Shared types and constants for the buddy block allocator.
// Holds field widths, status and action codes, the table entry layout and the
// controller state encoding. Depends on nothing.
package bba_pkg;

    // Field widths fixed by the item and register formats.
    localparam int ADDR_W    = 48;
    localparam int REQ_W     = 16;
    localparam int GRANT_W   = 13;
    localparam int STATUS_W  = 2;
    localparam int ORD_W     = 3;
    localparam int CFG_IDX_W = 2;
    // Request plus header never exceeds 17 bits.
    localparam int NEED_W    = REQ_W + 1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    // Item action codes.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_ORDER = 2'd1;

    localparam logic [ORD_W-1:0] HEAP_ORDER_RST = 3'd6;

    // One unit table entry: block starts here, block is taken, block order.
    typedef struct packed {
        logic             head;
        logic             taken;
        logic [ORD_W-1:0] ord;
    } t_entry;

    // One result item as it leaves the controller.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   data_address;
        logic [GRANT_W-1:0]  granted_bytes;
    } t_result;

    // Controller states.
    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_A_SIZE,
        S_A_SCAN,
        S_A_SPLIT,
        S_A_FIN,
        S_F_CHK,
        S_F_DIV,
        S_F_RD,
        S_F_EV,
        S_M_RD,
        S_M_EV,
        S_F_FIN,
        S_DONE
    } t_state;

endpackage

// ===== rtl/bba_if.sv =====
// Valid/ready channel interfaces of the buddy block allocator: request items,
// result items and configuration writes.
// Depends on bba_pkg for the field widths.
interface bba_item_if;
    import bba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [REQ_W-1:0]     request_bytes;
    logic [ADDR_W-1:0]    free_address;
    modport source(output valid, action, request_bytes, free_address, input ready);
    modport sink(input valid, action, request_bytes, free_address, output ready);
endinterface

interface bba_result_if;
    import bba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [ADDR_W-1:0]    data_address;
    logic [GRANT_W-1:0]   granted_bytes;
    modport source(output valid, status, data_address, granted_bytes, input ready);
    modport sink(input valid, status, data_address, granted_bytes, output ready);
endinterface

interface bba_cfg_if;
    import bba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/bba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module bba_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bba_outreg.sv =====
// Output register of the buddy block allocator: holds one result until the
// receiver takes it, so the controller may start the next item meanwhile.
// Depends on bba_pkg and bba_if.
module bba_outreg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  bba_pkg::t_result i_data,
    bba_result_if.source     o_res
);
    import bba_pkg::*;

    logic    r_valid;
    t_result r_data;

    // The register can load when empty or when its content leaves this cycle.
    assign o_ready = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.status        = r_data.status;
    assign o_res.data_address  = r_data.data_address;
    assign o_res.granted_bytes = r_data.granted_bytes;

endmodule

// ===== rtl/bba_ctrl.sv =====
// Controller of the buddy block allocator: configuration registers, table
// initialisation, allocate scan and split, free check, divide and merge.
// Depends on bba_pkg and bba_if; drives the unit table RAM ports.
module bba_ctrl #(
    parameter int MAX_UNITS       = 64,
    parameter int MIN_BLOCK_BYTES = 64,
    parameter int HEADER_BYTES    = 32,
    localparam int AW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bba_item_if.sink         i_in,
    bba_cfg_if.sink          i_cfg,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output bba_pkg::t_result o_res,
    output logic             o_we,
    output logic [AW-1:0]    o_waddr,
    output bba_pkg::t_entry  o_wdata,
    output logic [AW-1:0]    o_raddr,
    input  bba_pkg::t_entry  i_rdata
);
    import bba_pkg::*;

    // Largest usable heap order: floor(log2(MAX_UNITS)), at most 7.
    localparam int LOG_MAX  = $clog2(MAX_UNITS + 1) - 1;
    localparam int LIM      = (LOG_MAX > 7) ? 7 : LOG_MAX;
    localparam int UW       = LIM + 1;
    localparam int MB_W     = $clog2(MIN_BLOCK_BYTES);
    localparam int OFW      = LIM + MB_W + 1;
    localparam int SZW      = MB_W + 8;
    localparam int PW       = AW + MB_W + 1;
    localparam int MIN_FILL = MIN_BLOCK_BYTES - HEADER_BYTES;
    // Width that holds both a block size and a request plus header.
    localparam int CW       = (SZW > NEED_W) ? SZW : NEED_W;
    // Reciprocal of the unit size, exact for every offset below 2^OFW.
    localparam int     RS   = OFW + MB_W;
    localparam longint RM   = ((longint'(1) << RS) + longint'(MIN_BLOCK_BYTES) - 1)
                              / longint'(MIN_BLOCK_BYTES);
    localparam int     DPW  = 2 * OFW + 1;

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_heap_base, n_heap_base;
    logic [ORD_W-1:0]   r_heap_order, n_heap_order;
    logic [AW-1:0]      r_clr, n_clr;
    logic [NEED_W-1:0]  r_need, n_need;
    logic [ADDR_W-1:0]  r_off, n_off;
    logic [ORD_W-1:0]   r_k, n_k;
    logic [UW-1:0]      r_u, n_u;
    logic               r_found, n_found;
    logic [AW-1:0]      r_best, n_best;
    logic [ORD_W-1:0]   r_best_ord, n_best_ord;
    logic [OFW-1:0]     r_rem, n_rem;
    logic [AW-1:0]      r_q, n_q;
    logic [ORD_W-1:0]   r_o, n_o;
    t_result            r_res, n_res;

    logic [ORD_W-1:0]   eff;
    logic [UW-1:0]      units;

    // Effective heap order and heap size in units.
    assign eff   = (r_heap_order < ORD_W'(LIM)) ? r_heap_order : ORD_W'(LIM);
    assign units = UW'(1) << eff;

    assign i_cfg.ready = 1'b1;
    assign o_res       = r_res;

    // State and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_heap_base  <= '0;
            r_heap_order <= HEAP_ORDER_RST;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_heap_base  <= n_heap_base;
            r_heap_order <= n_heap_order;
        end
    end

    always_ff @(posedge i_clk) begin
        r_need     <= n_need;
        r_off      <= n_off;
        r_k        <= n_k;
        r_u        <= n_u;
        r_found    <= n_found;
        r_best     <= n_best;
        r_best_ord <= n_best_ord;
        r_rem      <= n_rem;
        r_q        <= n_q;
        r_o        <= n_o;
        r_res      <= n_res;
    end

    // Next state, table accesses and result.
    always_comb begin
        logic [ORD_W-1:0]  kk;
        logic              fit;
        logic              nf;
        logic [AW-1:0]     nb;
        logic [ORD_W-1:0]  nbo;
        logic              exact;
        logic [UW-1:0]     step;
        logic [UW-1:0]     nxt;
        logic [DPW-1:0]    recip;
        logic [OFW-1:0]    q_bytes;
        logic [AW-1:0]     bud;
        logic [AW-1:0]     lo;
        logic [AW-1:0]     hi;
        logic [ADDR_W-1:0] lim;
        logic [PW-1:0]     prod;
        logic [REQ_W-1:0]  req;

        n_state      = r_state;
        n_heap_base  = r_heap_base;
        n_heap_order = r_heap_order;
        n_clr        = r_clr;
        n_need       = r_need;
        n_off        = r_off;
        n_k          = r_k;
        n_u          = r_u;
        n_found      = r_found;
        n_best       = r_best;
        n_best_ord   = r_best_ord;
        n_rem        = r_rem;
        n_q          = r_q;
        n_o          = r_o;
        n_res        = r_res;

        i_in.ready  = 1'b0;
        o_res_valid = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_best;
        o_wdata     = '0;
        o_raddr     = '0;

        kk      = '0;
        fit     = 1'b0;
        nf      = r_found;
        nb      = r_best;
        nbo     = r_best_ord;
        exact   = 1'b0;
        step    = UW'(1);
        nxt     = '0;
        recip   = '0;
        q_bytes = OFW'(r_q) * OFW'(MIN_BLOCK_BYTES);
        bud     = r_q ^ (AW'(1) << r_o);
        lo      = (r_q < bud) ? r_q : bud;
        hi      = (r_q < bud) ? bud : r_q;
        lim     = ADDR_W'(MIN_BLOCK_BYTES) << eff;
        prod    = PW'(r_best) * PW'(MIN_BLOCK_BYTES);
        req     = (i_in.request_bytes < REQ_W'(MIN_FILL)) ? REQ_W'(MIN_FILL)
                                                          : i_in.request_bytes;

        case (r_state)
            // Sweep the table: one free block at unit zero, the rest empty.
            S_CLR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                if (r_clr == '0) begin
                    o_wdata = '{head: 1'b1, taken: 1'b0, ord: eff};
                end
                if (r_clr == AW'(MAX_UNITS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end

            // Take a request and do the first arithmetic for its action.
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    if (i_in.action == ACT_FREE) begin
                        n_off   = i_in.free_address - r_heap_base
                                  - ADDR_W'(HEADER_BYTES);
                        n_state = S_F_CHK;
                    end else begin
                        n_need  = NEED_W'(req) + NEED_W'(HEADER_BYTES);
                        n_state = S_A_SIZE;
                    end
                end
            end

            // Round the request up to a block order and start the scan at unit zero.
            S_A_SIZE: begin
                for (int i = 7; i >= 0; i--) begin
                    if ((CW'(MIN_BLOCK_BYTES) << i) >= CW'(r_need)) begin
                        kk  = ORD_W'(i);
                        fit = 1'b1;
                    end
                end
                if (!fit || kk > eff) begin
                    n_res   = '{status: ST_NO_SPACE, data_address: '0, granted_bytes: '0};
                    n_state = S_DONE;
                end else begin
                    n_k     = kk;
                    n_u     = '0;
                    n_found = 1'b0;
                    o_raddr = '0;
                    n_state = S_A_SCAN;
                end
            end

            // Walk the blocks in address order, one block per cycle.
            S_A_SCAN: begin
                if (i_rdata.head) begin
                    step = UW'(1) << i_rdata.ord;
                    if (!i_rdata.taken && i_rdata.ord >= r_k) begin
                        if (i_rdata.ord == r_k) begin
                            exact = 1'b1;
                            nf    = 1'b1;
                            nb    = AW'(r_u);
                            nbo   = i_rdata.ord;
                        end else if (!r_found || i_rdata.ord < r_best_ord) begin
                            nf  = 1'b1;
                            nb  = AW'(r_u);
                            nbo = i_rdata.ord;
                        end
                    end
                end
                nxt        = r_u + step;
                n_found    = nf;
                n_best     = nb;
                n_best_ord = nbo;
                if (exact) begin
                    n_state = S_A_SPLIT;
                end else if (nxt >= units) begin
                    if (nf) begin
                        n_state = S_A_SPLIT;
                    end else begin
                        n_res   = '{status: ST_NO_SPACE, data_address: '0,
                                    granted_bytes: '0};
                        n_state = S_DONE;
                    end
                end else begin
                    n_u     = nxt;
                    o_raddr = AW'(nxt);
                end
            end

            // Halve the chosen block, writing the free right half each cycle.
            S_A_SPLIT: begin
                if (r_best_ord > r_k) begin
                    o_we       = 1'b1;
                    o_waddr    = r_best + (AW'(1) << (r_best_ord - ORD_W'(1)));
                    o_wdata    = '{head: 1'b1, taken: 1'b0, ord: r_best_ord - ORD_W'(1)};
                    n_best_ord = r_best_ord - ORD_W'(1);
                end else begin
                    n_state = S_A_FIN;
                end
            end

            // Mark the block taken and form the grant.
            S_A_FIN: begin
                o_we    = 1'b1;
                o_waddr = r_best;
                o_wdata = '{head: 1'b1, taken: 1'b1, ord: r_k};
                n_res.status        = ST_OK;
                n_res.data_address  = r_heap_base + ADDR_W'(prod) + ADDR_W'(HEADER_BYTES);
                n_res.granted_bytes = GRANT_W'(SZW'(MIN_BLOCK_BYTES) << r_k);
                n_state = S_DONE;
            end

            // Reject offsets beyond the heap before dividing.
            S_F_CHK: begin
                if (r_off >= lim) begin
                    n_res   = '{status: ST_BAD_FREE, data_address: '0, granted_bytes: '0};
                    n_state = S_DONE;
                end else begin
                    n_rem   = OFW'(r_off);
                    n_state = S_F_DIV;
                end
            end

            // Unit index from the offset by multiplying with the reciprocal of the unit size.
            S_F_DIV: begin
                recip   = DPW'(r_rem) * DPW'(RM);
                n_q     = AW'(recip >> RS);
                n_state = S_F_RD;
            end

            // An offset that is not a whole number of units is not on a unit boundary.
            S_F_RD: begin
                if (q_bytes != r_rem) begin
                    n_res   = '{status: ST_BAD_FREE, data_address: '0, granted_bytes: '0};
                    n_state = S_DONE;
                end else begin
                    o_raddr = r_q;
                    n_state = S_F_EV;
                end
            end

            // The freed unit must start a taken block.
            S_F_EV: begin
                if (!i_rdata.head || !i_rdata.taken) begin
                    n_res   = '{status: ST_BAD_FREE, data_address: '0, granted_bytes: '0};
                    n_state = S_DONE;
                end else begin
                    n_o     = i_rdata.ord;
                    n_state = S_M_RD;
                end
            end

            // Fetch the buddy while the block is below the heap order.
            S_M_RD: begin
                if (r_o < eff) begin
                    o_raddr = bud;
                    n_state = S_M_EV;
                end else begin
                    n_state = S_F_FIN;
                end
            end

            // Merge with a free buddy of the same order; the upper head goes away.
            S_M_EV: begin
                if (i_rdata.head && !i_rdata.taken && i_rdata.ord == r_o) begin
                    o_we    = 1'b1;
                    o_waddr = hi;
                    o_wdata = '0;
                    n_q     = lo;
                    n_o     = r_o + ORD_W'(1);
                    n_state = S_M_RD;
                end else begin
                    n_state = S_F_FIN;
                end
            end

            // Write the merged block back as free.
            S_F_FIN: begin
                o_we    = 1'b1;
                o_waddr = r_q;
                o_wdata = '{head: 1'b1, taken: 1'b0, ord: r_o};
                n_res   = '{status: ST_OK, data_address: '0, granted_bytes: '0};
                n_state = S_DONE;
            end

            // Hand the result to the output register.
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_CLR;
                n_clr   = '0;
            end
        endcase

        // Configuration transfers; a new heap order restarts initialisation.
        if (i_cfg.valid) begin
            if (i_cfg.index == CFG_HEAP_BASE) begin
                n_heap_base = i_cfg.data;
            end else if (i_cfg.index == CFG_HEAP_ORDER) begin
                n_heap_order = ORD_W'(i_cfg.data);
                n_clr        = '0;
                n_state      = S_CLR;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // Reset always leads into the table initialisation sweep.
    a_rst_clr: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLR))
        else $error("reset did not start table initialisation");

    // No table write while waiting for a request.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_we)
        else $error("table written while idle");

    // The scan position stays inside the heap.
    a_scan_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_SCAN) |-> (r_u < units))
        else $error("scan ran past the heap");

    // Splitting never goes below the requested order.
    a_split_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_SPLIT) |-> (r_best_ord >= r_k))
        else $error("split below requested order");

    // Merging never exceeds the heap order.
    a_merge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M_RD || r_state == S_M_EV) |-> (r_o <= eff))
        else $error("merge beyond heap order");
`endif

endmodule

// ===== rtl/buddy_block_allocator.sv =====
// Buddy block allocator over a heap of 2^heap_order units of MIN_BLOCK_BYTES.
// Channels: i_in takes allocate/free requests, o_res gives one result per
// request, i_cfg writes heap_base (index 0) and heap_order (index 1).
// An allocate is accepted, its request sized, the blocks visited one at a time
// in the address-order scan (at most 2^heap_order), the chosen block halved
// step by step, then marked taken, and the result handed over; a request that
// exceeds the heap goes straight from sizing to the result.
// A free is accepted, its range checked, its unit found by reciprocal
// multiplication, the block checked and read, each buddy examined and merged in
// turn, and the merged block written back; a rejected free stops at its failed check.
// The pace is set by the single read port of the unit table.
// After reset, and after every heap_order transfer, the table is swept one
// entry a cycle over all MAX_UNITS entries; no request is taken meanwhile, while
// configuration transfers are still accepted. Items are handled one at a time.
// The result sits in an output register: a stalled receiver holds it there,
// and the next request is still taken and worked on until its own result has
// to wait for that register to empty.
module buddy_block_allocator #(
    parameter int MAX_UNITS       = 64,
    parameter int MIN_BLOCK_BYTES = 64,
    parameter int HEADER_BYTES    = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bba_item_if.sink      i_in,
    bba_result_if.source  o_res,
    bba_cfg_if.sink       i_cfg
);
    import bba_pkg::*;

    localparam int AW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;

    logic          res_valid;
    logic          res_ready;
    t_result       res_data;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    t_entry        ram_wdata;
    t_entry        ram_rdata;

    // Unit table: one entry per unit.
    bba_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_UNITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer for allocate, free and table initialisation.
    bba_ctrl #(
        .MAX_UNITS       (MAX_UNITS),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .HEADER_BYTES    (HEADER_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res_data),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_raddr     (ram_raddr),
        .i_rdata     (ram_rdata)
    );

    // Result register towards the receiver.
    bba_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_data  (res_data),
        .o_res   (o_res)
    );

endmodule

// ===== tb/sv/bba_answer_checker.sv =====
// Answer checker for the buddy block allocator testbench.
// Watches the request, result and configuration channels, keeps its own copy of the heap
// and compares every result transfer. Depends on bba_pkg and the channel interfaces in bba_if.
module bba_answer_checker #(
    parameter int MAX_UNITS       = 64,
    parameter int MIN_BLOCK_BYTES = 64,
    parameter int HEADER_BYTES    = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bba_item_if   in_ch,
    bba_result_if res_ch,
    bba_cfg_if    cfg_ch,
    output int    o_errors,
    output int    o_pending
);
    import bba_pkg::*;

    logic [ADDR_W-1:0] base_q;
    logic [ORD_W-1:0]  order_q;
    logic              blk_head  [MAX_UNITS];
    logic              blk_taken [MAX_UNITS];
    logic [ORD_W-1:0]  blk_ord   [MAX_UNITS];
    t_result           awaited_answers [$];
    int                answers_seen = 0;
    int                error_tally  = 0;
    int                awaited_count = 0;

    assign o_errors  = error_tally;
    assign o_pending = awaited_count;

    // Every mismatch prints one line and is counted.
    task automatic flag_error(input string msg);
        $display("ERROR: %s", msg);
        error_tally++;
    endtask

    // Largest order that fits the table; a larger heap_order is clipped to it.
    function automatic int usable_order();
        int lim;
        lim = 0;
        while (lim < 7 && (2 << lim) <= MAX_UNITS) lim++;
        return (int'(order_q) < lim) ? int'(order_q) : lim;
    endfunction

    // Rebuild the heap as one free block starting at unit 0.
    function automatic void carve_heap();
        for (int i = 0; i < MAX_UNITS; i++) begin
            blk_head[i]  = 1'b0;
            blk_taken[i] = 1'b0;
            blk_ord[i]   = '0;
        end
        blk_head[0] = 1'b1;
        blk_ord[0]  = ORD_W'(usable_order());
    endfunction

    // Size the request, pick the first exact fit or else the first smallest larger block,
    // then halve it keeping the left half.
    function automatic t_result grant_block(input logic [REQ_W-1:0] req);
        t_result ans;
        int      ord, need, k, u, best, o, r;
        bit      found;
        ans        = '0;
        ans.status = ST_NO_SPACE;
        ord  = usable_order();
        need = int'(req);
        if (need < MIN_BLOCK_BYTES - HEADER_BYTES) need = MIN_BLOCK_BYTES - HEADER_BYTES;
        need += HEADER_BYTES;
        k = 0;
        while (k <= ord && (MIN_BLOCK_BYTES << k) < need) k++;
        if (k > ord) return ans;

        u     = 0;
        best  = 0;
        found = 1'b0;
        while (u < (1 << ord)) begin
            if (!blk_head[u]) begin
                u++;
                continue;
            end
            if (!blk_taken[u] && int'(blk_ord[u]) >= k) begin
                if (int'(blk_ord[u]) == k) begin
                    best  = u;
                    found = 1'b1;
                    break;
                end
                if (!found || blk_ord[u] < blk_ord[best]) begin
                    best  = u;
                    found = 1'b1;
                end
            end
            u += 1 << blk_ord[u];
        end
        if (!found) return ans;

        while (int'(blk_ord[best]) > k) begin
            o = int'(blk_ord[best]) - 1;
            r = best + (1 << o);
            blk_ord[best] = ORD_W'(o);
            if (r < MAX_UNITS) begin
                blk_head[r]  = 1'b1;
                blk_taken[r] = 1'b0;
                blk_ord[r]   = ORD_W'(o);
            end
        end
        blk_taken[best]   = 1'b1;
        ans.status        = ST_OK;
        ans.data_address  = base_q + ADDR_W'(best * MIN_BLOCK_BYTES) + ADDR_W'(HEADER_BYTES);
        ans.granted_bytes = GRANT_W'(MIN_BLOCK_BYTES << k);
        return ans;
    endfunction

    // Check the address names a taken block, release it and merge buddies upward.
    function automatic t_result release_block(input logic [ADDR_W-1:0] addr);
        t_result           ans;
        logic [ADDR_W-1:0] off, q;
        int                ord, u, o, b, lo, hi;
        ans        = '0;
        ans.status = ST_BAD_FREE;
        ord = usable_order();
        off = addr - base_q - ADDR_W'(HEADER_BYTES);
        if (off % MIN_BLOCK_BYTES != 0) return ans;
        q = off / MIN_BLOCK_BYTES;
        if (q >= (1 << ord)) return ans;
        u = int'(q);
        if (!blk_head[u] || !blk_taken[u]) return ans;

        blk_taken[u] = 1'b0;
        while (int'(blk_ord[u]) < ord) begin
            o = int'(blk_ord[u]);
            b = u ^ (1 << o);
            if (b >= MAX_UNITS || !blk_head[b] || blk_taken[b] || int'(blk_ord[b]) != o) break;
            lo = (u < b) ? u : b;
            hi = (u < b) ? b : u;
            blk_head[hi] = 1'b0;
            blk_ord[hi]  = '0;
            blk_ord[lo]  = ORD_W'(o + 1);
            u = lo;
        end
        ans.status = ST_OK;
        return ans;
    endfunction

    // Follow every transfer at the rising edge and keep the expected answers in order.
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            base_q  = '0;
            order_q = HEAP_ORDER_RST;
            carve_heap();
            awaited_answers.delete();
        end else begin
            // A result always belongs to a request taken at an earlier edge, so match it first.
            if (res_ch.valid && res_ch.ready) begin
                answers_seen++;
                if (awaited_answers.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with no request outstanding",
                                         answers_seen));
                end else begin
                    want = awaited_answers.pop_front();
                    if (res_ch.status !== want.status)
                        flag_error($sformatf("result %0d status: got %0d, expected %0d",
                                             answers_seen, res_ch.status, want.status));
                    if (res_ch.data_address !== want.data_address)
                        flag_error($sformatf("result %0d data_address: got %0h, expected %0h",
                                             answers_seen, res_ch.data_address,
                                             want.data_address));
                    if (res_ch.granted_bytes !== want.granted_bytes)
                        flag_error($sformatf("result %0d granted_bytes: got %0d, expected %0d",
                                             answers_seen, res_ch.granted_bytes,
                                             want.granted_bytes));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == CFG_HEAP_BASE) begin
                    base_q = cfg_ch.data;
                end else if (cfg_ch.index == CFG_HEAP_ORDER) begin
                    order_q = cfg_ch.data[ORD_W-1:0];
                    carve_heap();
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.action == ACT_FREE) begin
                    awaited_answers.push_back(release_block(in_ch.free_address));
                end else begin
                    awaited_answers.push_back(grant_block(in_ch.request_bytes));
                end
            end
        end
        awaited_count = awaited_answers.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the buddy block allocator testbench: clock, reset, stimulus and the verdict.
// Instantiates buddy_block_allocator and bba_answer_checker side by side.
// Depends on bba_pkg and the channel interfaces in bba_if.
module tb;
    import bba_pkg::*;

    localparam int MAX_UNITS       = 64;
    localparam int MIN_BLOCK_BYTES = 64;
    localparam int HEADER_BYTES    = 32;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int LONG_HOLD       = 400;
    localparam int END_SETTLE      = 100;
    localparam int N_PHASES        = 8;
    // Indexes that name no register; writes to them must leave the block untouched.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [ADDR_W-1:0]    ADDR_ONES   = '1;

    logic i_clk;
    logic i_rst_n;

    bba_item_if   in_if ();
    bba_result_if res_if ();
    bba_cfg_if    cfg_if ();

    int                errors;
    int                awaiting;
    int                cycle_count;
    logic              hold_off_req;
    logic              calm;
    int                gap_pct;
    logic [ADDR_W-1:0] cur_base;
    logic [ORD_W-1:0]  cur_order;
    logic [ADDR_W-1:0] live_addrs [$];
    logic [ADDR_W-1:0] last_freed;

    buddy_block_allocator #(
        .MAX_UNITS       (MAX_UNITS),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .HEADER_BYTES    (HEADER_BYTES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    bba_answer_checker #(
        .MAX_UNITS       (MAX_UNITS),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .HEADER_BYTES    (HEADER_BYTES)
    ) answer_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_if),
        .res_ch    (res_if),
        .cfg_ch    (cfg_if),
        .o_errors  (errors),
        .o_pending (awaiting)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Ends a run that has stopped making progress.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Granted addresses are collected so that most frees name a live block.
    always @(posedge i_clk) begin : harvest
        if (i_rst_n && res_if.valid && res_if.ready && res_if.status == ST_OK &&
            res_if.granted_bytes != '0) begin
            live_addrs.push_back(res_if.data_address);
        end
    end

    // Receiver: stall bursts whose density is chosen anew at random, plus one long hold.
    initial begin : result_sink
        int stall_left, stall_pct, mode_left;
        stall_left   = 0;
        stall_pct    = 0;
        mode_left    = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    default: stall_pct = 40;
                endcase
                mode_left = 100;
            end
            mode_left--;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = LONG_HOLD;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 10);
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    // Order of the heap in use, with an oversized heap_order clipped to the table.
    function automatic int live_order();
        int lim;
        lim = $clog2(MAX_UNITS + 1) - 1;
        return (int'(cur_order) < lim) ? int'(cur_order) : lim;
    endfunction

    function automatic logic [ADDR_W-1:0] unit_addr(input int u);
        return cur_base + ADDR_W'(u * MIN_BLOCK_BYTES) + ADDR_W'(HEADER_BYTES);
    endfunction

    // Every stimulus task is entered and left at a falling edge.
    task automatic send_item(input logic act, input logic [REQ_W-1:0] req,
                             input logic [ADDR_W-1:0] addr);
        in_if.valid         <= 1'b1;
        in_if.action        <= act;
        in_if.request_bytes <= req;
        in_if.free_address  <= addr;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause_items(input int n);
        in_if.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Hold the request channel until every outstanding answer has been taken.
    task automatic drain();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (awaiting != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
        if (idx == CFG_HEAP_BASE) begin
            // The heap keeps its blocks, so live addresses move with the base.
            foreach (live_addrs[i]) live_addrs[i] = live_addrs[i] - cur_base + value;
            cur_base = value;
        end else if (idx == CFG_HEAP_ORDER) begin
            cur_order = value[ORD_W-1:0];
            live_addrs.delete();
        end
    endtask

    // Mostly allocations and frees of live blocks; the rest are malformed frees.
    task automatic random_item();
        int                eff, pick, sel, k;
        logic [REQ_W-1:0]  req;
        logic [ADDR_W-1:0] addr;
        eff  = live_order();
        req  = REQ_W'($urandom());
        addr = rand_addr();
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            case ($urandom_range(0, 3))
                0: ;
                1: begin
                    if (live_addrs.size() != 0)
                        addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
                    else
                        addr = unit_addr($urandom_range(0, (1 << eff) - 1));
                    addr = addr + ADDR_W'($urandom_range(1, MIN_BLOCK_BYTES - 1));
                end
                2: addr = last_freed;
                default: addr = unit_addr($urandom_range(0, (1 << eff) + 3));
            endcase
            send_item(ACT_FREE, req, addr);
        end else if (live_addrs.size() != 0 && pick < (live_addrs.size() >= 8 ? 62 : 40)) begin
            sel  = $urandom_range(0, live_addrs.size() - 1);
            addr = live_addrs[sel];
            live_addrs.delete(sel);
            last_freed = addr;
            send_item(ACT_FREE, req, addr);
        end else begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                req = REQ_W'($urandom_range(0, MIN_BLOCK_BYTES - HEADER_BYTES));
            end else if (sel < 70) begin
                k   = (eff < 2) ? eff : 2;
                req = REQ_W'($urandom_range(0, (MIN_BLOCK_BYTES << k) - HEADER_BYTES));
            end else if (sel < 88) begin
                req = REQ_W'($urandom_range(0, (MIN_BLOCK_BYTES << eff) - HEADER_BYTES));
            end else if (sel < 94) begin
                // Right on a block boundary or one byte over it.
                k   = $urandom_range(0, eff);
                req = REQ_W'((MIN_BLOCK_BYTES << k) - HEADER_BYTES + $urandom_range(0, 1));
            end
            send_item(ACT_ALLOC, req, addr);
        end
    endtask

    initial begin : stimulus
        logic [ADDR_W-1:0] ph_base  [N_PHASES];
        int                ph_order [N_PHASES];
        int                ph_items [N_PHASES];
        int                whole;

        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.action        = ACT_ALLOC;
        in_if.request_bytes = '0;
        in_if.free_address  = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = CFG_HEAP_BASE;
        cfg_if.data         = '0;
        hold_off_req        = 1'b0;
        calm                = 1'b0;
        gap_pct             = 0;
        cur_base            = '0;
        cur_order           = HEAP_ORDER_RST;
        last_freed          = '0;

        // Heap settings per phase; an order of -1 moves the base over the existing heap.
        ph_base[0] = '0;          ph_order[0] = 6;  ph_items[0] = 300;
        ph_base[1] = rand_addr(); ph_order[1] = 0;  ph_items[1] = 80;
        ph_base[2] = rand_addr(); ph_order[2] = 7;  ph_items[2] = 200;
        ph_base[3] = rand_addr(); ph_order[3] = 3;  ph_items[3] = 150;
        ph_base[4] = rand_addr(); ph_order[4] = -1; ph_items[4] = 100;
        ph_base[5] = ADDR_ONES;   ph_order[5] = 5;  ph_items[5] = 170;
        ph_base[6] = rand_addr(); ph_order[6] = 1;  ph_items[6] = 100;
        ph_base[7] = rand_addr(); ph_order[7] = 6;  ph_items[7] = 200;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the reset heap, with a base that makes addresses wrap.
        write_reg(CFG_HEAP_BASE, ADDR_ONES);
        whole = (MIN_BLOCK_BYTES << live_order()) - HEADER_BYTES;
        send_item(ACT_ALLOC, '0, '0);
        send_item(ACT_ALLOC, REQ_W'(MIN_BLOCK_BYTES - HEADER_BYTES), '0);
        send_item(ACT_ALLOC, REQ_W'(MIN_BLOCK_BYTES - HEADER_BYTES + 1), '0);
        send_item(ACT_ALLOC, REQ_W'(whole), '0);
        send_item(ACT_ALLOC, '1, '0);
        send_item(ACT_FREE, '0, unit_addr(0) + 1);
        send_item(ACT_FREE, '0, unit_addr(1 << live_order()));
        send_item(ACT_FREE, '0, unit_addr(3));
        send_item(ACT_FREE, '0, unit_addr(4));
        send_item(ACT_FREE, '0, unit_addr(0));
        send_item(ACT_FREE, '0, unit_addr(0));
        send_item(ACT_FREE, '0, unit_addr(1));
        send_item(ACT_FREE, '0, unit_addr(2));
        send_item(ACT_ALLOC, REQ_W'(whole), '0);
        send_item(ACT_ALLOC, '0, '0);
        send_item(ACT_FREE, '0, unit_addr(0));
        send_item(ACT_FREE, '1, '0);
        send_item(ACT_FREE, '0, ADDR_ONES);
        send_item(ACT_ALLOC, REQ_W'(MIN_BLOCK_BYTES - HEADER_BYTES), ADDR_ONES);
        send_item(ACT_ALLOC, REQ_W'(3 * MIN_BLOCK_BYTES), '0);
        send_item(ACT_ALLOC, '0, '0);
        send_item(ACT_FREE, '0, unit_addr(0));
        send_item(ACT_ALLOC, REQ_W'(MIN_BLOCK_BYTES), '0);
        send_item(ACT_FREE, '0, unit_addr(1));

        // Random phases, each on a freshly configured heap but phase 4, which only moves the base.
        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            if (p == N_PHASES - 1) calm = 1'b1;
            write_reg(CFG_HEAP_BASE, ph_base[p]);
            if (ph_order[p] >= 0) write_reg(CFG_HEAP_ORDER, ADDR_W'(ph_order[p]));
            if (p == 3) begin
                write_reg(CFG_SPARE_A, rand_addr());
                write_reg(CFG_SPARE_B, rand_addr());
            end
            for (int n = 0; n < ph_items[p]; n++) begin
                if (n % 40 == 0) begin
                    case ($urandom_range(0, 2))
                        0: gap_pct = 0;
                        1: gap_pct = 10;
                        default: gap_pct = 35;
                    endcase
                end
                // The receiver holds off while requests keep coming, filling the block.
                if (p == 0 && n == 150) hold_off_req = 1'b1;
                if (p == 2 && n == 100) drain();
                if (!calm && $urandom_range(0, 99) < gap_pct) pause_items($urandom_range(1, 10));
                random_item();
            end
        end

        drain();
        repeat (END_SETTLE) @(negedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
